// ----- hdl/tur_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the TCP/UDP port remap block.
// No dependencies; every other file of the block imports this package.
package tur_pkg;

    // Number of mapping cells in the chain.
    localparam int MAP_ENTRIES = 6;

    // Field and register widths.
    localparam int PORT_W  = 16;
    localparam int PROTO_W = 8;
    localparam int ENTRY_W = 33;
    localparam int CNT_W   = 3;
    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 3;

    // IP protocol numbers.
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_ENTRIES   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAP_FIRST = 3'd1;

    // Bit positions inside a mapping entry.
    localparam int ENTRY_KIND_BIT = 32;

    // Header fields as they travel down the chain of cells.
    typedef struct packed {
        logic              is_tcp;
        logic              is_udp;
        logic [PORT_W-1:0] src0;
        logic [PORT_W-1:0] dst0;
        logic [PORT_W-1:0] src;
        logic [PORT_W-1:0] dst;
        logic [PORT_W-1:0] csum;
    } t_item;

    // Ones' complement addition of two 16-bit words with end-around carry.
    function automatic logic [PORT_W-1:0] oc_add(input logic [PORT_W-1:0] a,
                                                 input logic [PORT_W-1:0] b);
        logic [PORT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        oc_add = s[PORT_W-1:0] + {{(PORT_W-1){1'b0}}, s[PORT_W]};
    endfunction

endpackage

// ----- hdl/tcp_udp_port_remap_core.sv -----
`timescale 1ns / 1ps
// Top level of the TCP/UDP port remap block: configuration registers, a chain
// of mapping cells and the checksum stage. Depends on tur_pkg, tur_cell, tur_csum.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+---------------------------------------------
//  input    | i_valid / o_stall          | i_ip_protocol, i_in_src_port, i_in_dst_port,
//           |                            | i_in_checksum
//  output   | o_valid / i_stall          | o_out_src_port, o_out_dst_port,
//           |                            | o_out_checksum, o_was_changed
//  config   | psel, penable, pwrite      | paddr (8-byte steps), pwdata, prdata, pready
//
// Each item passes in turn through each of the six mapping cells and then the
// output register. One item is accepted every cycle while o_stall is low;
// each stage holds one item and moves on whenever the stage after it frees up.
// A stall on the output holds the output register, and the chain behind it
// fills up before o_stall rises. Reset is synchronous and clears the valid flag
// of every stage and the configuration registers.
module tcp_udp_port_remap_core import tur_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input items
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [PROTO_W-1:0] i_ip_protocol,
    input  logic [PORT_W-1:0]  i_in_src_port,
    input  logic [PORT_W-1:0]  i_in_dst_port,
    input  logic [PORT_W-1:0]  i_in_checksum,
    // Result items
    output logic               o_valid,
    input  logic               i_stall,
    output logic [PORT_W-1:0]  o_out_src_port,
    output logic [PORT_W-1:0]  o_out_dst_port,
    output logic [PORT_W-1:0]  o_out_checksum,
    output logic               o_was_changed,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [CNT_W-1:0]   r_entries_in_use;
    logic               w_wr;
    logic [IDX_W-1:0]   w_idx;
    logic [ENTRY_W-1:0] w_entry [MAP_ENTRIES];
    logic               w_valid [MAP_ENTRIES+1];
    t_item              w_item  [MAP_ENTRIES+1];
    logic               w_ready [MAP_ENTRIES+1];

    // Register decode: one register every eight bytes.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= '0;
        end else if (w_wr && (w_idx == REG_ENTRIES)) begin
            r_entries_in_use <= pwdata[CNT_W-1:0];
        end
    end

    // Register read back.
    always_comb begin
        prdata = '0;
        if (w_idx == REG_ENTRIES) begin
            prdata = {{(DATA_W-CNT_W){1'b0}}, r_entries_in_use};
        end
        for (int k = 0; k < MAP_ENTRIES; k++) begin
            if (w_idx == IDX_W'(int'(REG_MAP_FIRST) + k)) begin
                prdata = {{(DATA_W-ENTRY_W){1'b0}}, w_entry[k]};
            end
        end
    end

    // Header item entering the chain.
    always_comb begin
        w_item[0].is_tcp = (i_ip_protocol == PROTO_TCP);
        w_item[0].is_udp = (i_ip_protocol == PROTO_UDP);
        w_item[0].src0   = i_in_src_port;
        w_item[0].dst0   = i_in_dst_port;
        w_item[0].src    = i_in_src_port;
        w_item[0].dst    = i_in_dst_port;
        w_item[0].csum   = i_in_checksum;
    end

    assign w_valid[0] = i_valid;
    assign o_stall    = !w_ready[0];

    // Chain of mapping cells; a count above the table size enables them all.
    for (genvar k = 0; k < MAP_ENTRIES; k++) begin : g_cell
        tur_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cfg_we     (w_wr && (w_idx == IDX_W'(int'(REG_MAP_FIRST) + k))),
            .i_cfg_data   (pwdata[ENTRY_W-1:0]),
            .o_entry      (w_entry[k]),
            .i_active     (CNT_W'(k) < r_entries_in_use),
            .i_valid      (w_valid[k]),
            .i_item       (w_item[k]),
            .o_ready      (w_ready[k]),
            .i_next_ready (w_ready[k+1]),
            .o_valid      (w_valid[k+1]),
            .o_item       (w_item[k+1])
        );
    end

    // Checksum update and output register.
    tur_csum u_csum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_valid[MAP_ENTRIES]),
        .i_item         (w_item[MAP_ENTRIES]),
        .o_ready        (w_ready[MAP_ENTRIES]),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_src_port (o_out_src_port),
        .o_out_dst_port (o_out_dst_port),
        .o_out_checksum (o_out_checksum),
        .o_was_changed  (o_was_changed)
    );

    // With the output register empty, the block never refuses an item.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while the output register is empty");

    // The input only stalls behind a result that is held on the output.
    a_stall_needs_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // A stalled result stays on the output unchanged.
    a_held_result_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_src_port) &&
        $stable(o_out_dst_port) && $stable(o_out_checksum) && $stable(o_was_changed)))
        else $error("stalled result changed");

endmodule

// ----- hdl/tur_cell.sv -----
`timescale 1ns / 1ps
// One mapping cell: holds a single mapping entry and rewrites the ports of the
// item passing through it. Depends on tur_pkg.
module tur_cell import tur_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ENTRY_W-1:0] i_cfg_data,
    output logic [ENTRY_W-1:0] o_entry,
    input  logic               i_active,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_ready,
    input  logic               i_next_ready,
    output logic               o_valid,
    output t_item              o_item
);

    logic [ENTRY_W-1:0] r_entry;
    logic               r_valid;
    t_item              r_item;
    t_item              n_item;
    logic [PORT_W-1:0]  w_from;
    logic [PORT_W-1:0]  w_to;
    logic               w_apply;

    // Mapping entry, written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_cfg_we) begin
            r_entry <= i_cfg_data;
        end
    end

    assign o_entry = r_entry;
    assign w_from  = r_entry[2*PORT_W-1:PORT_W];
    assign w_to    = r_entry[PORT_W-1:0];

    // The entry applies when it is active and its protocol matches the item.
    assign w_apply = i_active &&
                     ((i_item.is_tcp && !r_entry[ENTRY_KIND_BIT]) ||
                      (i_item.is_udp &&  r_entry[ENTRY_KIND_BIT]));

    // Destination rewrite and the reverse rewrite of the source, both tested on the incoming ports.
    always_comb begin
        n_item = i_item;
        if (w_apply) begin
            if (i_item.dst == w_from) begin
                n_item.dst = w_to;
            end
            if (i_item.src == w_to) begin
                n_item.src = w_from;
            end
        end
    end

    // The stage takes a new item when empty or when its item moves on.
    assign o_ready = !r_valid || i_next_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hdl/tur_csum.sv -----
`timescale 1ns / 1ps
// Checksum update and output register: applies the incremental checksum
// update to the rewritten ports and holds the result item. Depends on tur_pkg.
module tur_csum import tur_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_item             i_item,
    output logic              o_ready,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [PORT_W-1:0] o_out_src_port,
    output logic [PORT_W-1:0] o_out_dst_port,
    output logic [PORT_W-1:0] o_out_checksum,
    output logic              o_was_changed
);

    logic              r_valid;
    logic [PORT_W-1:0] r_src;
    logic [PORT_W-1:0] r_dst;
    logic [PORT_W-1:0] r_csum;
    logic              r_changed;
    logic              w_changed;
    logic              w_udp_none;
    logic [PORT_W-1:0] w_sum;
    logic [PORT_W-1:0] w_upd;
    logic [PORT_W-1:0] n_csum;

    // A rewrite happened when either final port differs from its input.
    assign w_changed  = (i_item.src != i_item.src0) || (i_item.dst != i_item.dst0);
    assign w_udp_none = i_item.is_udp && (i_item.csum == '0);

    // Incremental update: HC' = ~(~HC + ~m + m') over both port words.
    always_comb begin
        w_sum = oc_add(~i_item.csum, ~i_item.src0);
        w_sum = oc_add(w_sum, i_item.src);
        w_sum = oc_add(w_sum, ~i_item.dst0);
        w_sum = oc_add(w_sum, i_item.dst);
        w_upd = ~w_sum;
    end

    // Select the checksum to send; a computed UDP zero goes out as all ones.
    always_comb begin
        n_csum = i_item.csum;
        if (w_changed && !w_udp_none) begin
            if (i_item.is_udp && (w_upd == '0)) begin
                n_csum = '1;
            end else begin
                n_csum = w_upd;
            end
        end
    end

    // The output register holds a stalled result and takes a new item when it
    // is empty or when its result is taken in the same cycle.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_src     <= i_item.src;
            r_dst     <= i_item.dst;
            r_csum    <= n_csum;
            r_changed <= w_changed;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_src_port = r_src;
    assign o_out_dst_port = r_dst;
    assign o_out_checksum = r_csum;
    assign o_was_changed  = r_changed;

    // Unchanged ports must leave the checksum as received.
    a_unchanged_keeps_csum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !w_changed) |-> (n_csum == i_item.csum))
        else $error("checksum altered although no port was rewritten");

    // Protocols other than TCP and UDP never see a rewrite.
    a_other_proto_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_item.is_tcp && !i_item.is_udp) |-> !w_changed)
        else $error("port rewritten for a protocol other than TCP or UDP");

    // A UDP item with a checksum present never leaves with a zero checksum.
    a_udp_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_item.is_udp && (i_item.csum != '0)) |-> (n_csum != '0))
        else $error("UDP checksum became zero");

endmodule
